@@ hdl/ppd_pkg.sv @@
// shared types, defaults and helper functions for the point to plane block
// no dependencies; the interfaces, ppd_regs, the top level, the checker and the bench refer to this package
package ppd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    REG_PLANE_A,
    REG_PLANE_B,
    REG_PLANE_C,
    REG_PLANE_D
  } reg_idx_t;

  // plane status handed from the register block to the datapath
  typedef struct packed {
    logic       degen;
    logic [2:0] nneg;
  } plane_flags_t;

  function automatic int apb_data_w(int coord_w);
    return (coord_w > 32) ? 64 : 32;
  endfunction

  function automatic int apb_addr_w(int coord_w);
    return (coord_w > 32) ? 5 : 4;
  endfunction

endpackage

@@ hdl/ppd_if.sv @@
// valid/ready channel interfaces for points in and results out
// depends on ppd_pkg for the default coordinate width
interface ppd_point_if #(
  parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppd_result_if #(
  parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH-1:0] distance;
  logic signed [COORD_WIDTH-1:0] foot_x;
  logic signed [COORD_WIDTH-1:0] foot_y;
  logic signed [COORD_WIDTH-1:0] foot_z;
  logic                          degenerate_plane;
  logic                          saturated;

  modport source (output valid, distance, foot_x, foot_y, foot_z, degenerate_plane,
                  saturated, input ready);
  modport sink   (input valid, distance, foot_x, foot_y, foot_z, degenerate_plane,
                  saturated, output ready);
endinterface

@@ hdl/ppd_regs.sv @@
// plane registers on an apb style port, plus values derived from them
// (normal magnitudes, squared norm, sign and degenerate flags); uses ppd_pkg
module ppd_regs #(
  parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ppd_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [ppd_pkg::apb_addr_w(COORD_WIDTH)-1:0]       paddr,
  input  logic [ppd_pkg::apb_data_w(COORD_WIDTH)-1:0]       pwdata,
  output logic [ppd_pkg::apb_data_w(COORD_WIDTH)-1:0]       prdata,
  output logic [2:0][COORD_WIDTH-1:0]                       plane_n,
  output logic [COORD_WIDTH-1:0]                            plane_d,
  output logic [2:0][COORD_WIDTH-1:0]                       nabs,
  output logic [2*COORD_WIDTH-1:0]                          nn,
  output ppd_pkg::plane_flags_t                             flags
);
  localparam int W      = COORD_WIDTH;
  localparam int ADDR_W = ppd_pkg::apb_addr_w(W);
  localparam int DATA_W = ppd_pkg::apb_data_w(W);

  logic [W-1:0]       plane_a, plane_b, plane_c;
  logic [2:0][2*W-1:0] sq;
  ppd_pkg::reg_idx_t  idx;

  assign idx = ppd_pkg::reg_idx_t'(paddr[ADDR_W-1:ADDR_W-2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_a <= '0;
      plane_b <= '0;
      plane_c <= W'(1) << FRAC_BITS;
      plane_d <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        ppd_pkg::REG_PLANE_A: plane_a <= pwdata[W-1:0];
        ppd_pkg::REG_PLANE_B: plane_b <= pwdata[W-1:0];
        ppd_pkg::REG_PLANE_C: plane_c <= pwdata[W-1:0];
        ppd_pkg::REG_PLANE_D: plane_d <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppd_pkg::REG_PLANE_A: prdata = DATA_W'(plane_a);
      ppd_pkg::REG_PLANE_B: prdata = DATA_W'(plane_b);
      ppd_pkg::REG_PLANE_C: prdata = DATA_W'(plane_c);
      ppd_pkg::REG_PLANE_D: prdata = DATA_W'(plane_d);
      default:              prdata = '0;
    endcase
  end

  assign plane_n = {plane_c, plane_b, plane_a};

  // flags are read by an item straight after a write, so no register here
  always_comb begin
    flags.degen = (plane_a == '0) && (plane_b == '0) && (plane_c == '0);
    flags.nneg  = {plane_c[W-1], plane_b[W-1], plane_a[W-1]};
  end

  // derived values are registered (nabs directly, nn after the squares in sq), well before any item needs them
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nabs[i] <= plane_n[i][W-1] ? W'(-plane_n[i]) : plane_n[i];
      sq[i]   <= (2*W)'($signed(plane_n[i]) * $signed(plane_n[i]));
    end
    nn <= sq[0] + sq[1] + sq[2];
  end

endmodule

@@ hdl/ppd_delay.sv @@
// enabled shift line that keeps side data level with the long datapath units
// no package dependency
module ppd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        tap[k] <= tap[k-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

@@ hdl/ppd_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, with an overflow
// flag when the quotient does not fit Q_W bits; no package dependency
module ppd_divider #(
  parameter int NUM_W = 130,
  parameter int DEN_W = 64,
  parameter int Q_W   = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);
  localparam int HW = NUM_W - Q_W;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic [DEN_W-1:0] rem   [Q_W+1];
  logic [Q_W-1:0]   low   [Q_W+1];
  logic [Q_W-1:0]   q     [Q_W+1];
  logic             ovf_s [Q_W+1];
  logic [CW-1:0]    head;

  assign head = CW'(num >> Q_W);

  // the upper part must stay below the divisor or the quotient overflows
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= head[DEN_W-1:0];
      low[0]   <= num[Q_W-1:0];
      q[0]     <= '0;
      ovf_s[0] <= head >= CW'(den);
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem[s], low[s][Q_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]   <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        low[s+1]   <= low[s] << 1;
        q[s+1]     <= {q[s][Q_W-2:0], ge};
        ovf_s[s+1] <= ovf_s[s];
      end
    end
  end

  assign quo = q[Q_W];
  assign ovf = ovf_s[Q_W];

endmodule

@@ hdl/ppd_isqrt.sv @@
// pipelined integer square root, one root bit per stage (restoring form)
// no package dependency
module ppd_isqrt #(
  parameter int ROOT_W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);
  localparam int RW = ROOT_W + 2;

  logic [RW-1:0]       rem [ROOT_W+1];
  logic [ROOT_W-1:0]   rt  [ROOT_W+1];
  logic [2*ROOT_W-1:0] rd  [ROOT_W+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    assign cur   = {rem[s], rd[s][2*ROOT_W-1 -: 2]};
    assign trial = (RW+2)'({rt[s], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? RW'(cur - trial) : RW'(cur);
        rt[s+1]  <= {rt[s][ROOT_W-2:0], ge};
        rd[s+1]  <= rd[s] << 2;
      end
    end
  end

  assign root = rt[ROOT_W];

endmodule

@@ hdl/point_plane_distance_projection.sv @@
// Point to plane distance and foot point, streaming one point per cycle unless the output stalls.
// Channels: pnt takes a point (point_x/y/z, signed fixed point) on valid and
// ready; res gives distance, foot_x/y/z, degenerate_plane and saturated on
// valid and ready. The plane a, b, c, d sits in four registers on the apb port;
// the user writes it only while no point is in flight, the block does not enforce this.
// The distance path is the divider for dot^2/|n|^2, one quotient bit a
// stage, followed by the square root, one root bit a stage. The foot point
// dividers run alongside with their results held in a delay line.
// Throughput is one point per cycle while res.ready is high.
// When the receiver stalls the whole pipeline holds and pnt.ready drops in the
// same cycle; nothing is lost or repeated, bubbles are not squeezed out.
// Reset clears the valid bits of every stage and loads the default plane
// (normal 0,0,1, offset 0); results in flight are dropped.
// Depends on ppd_pkg, ppd_if, ppd_regs, ppd_delay, ppd_divider, ppd_isqrt.
module point_plane_distance_projection #(
  parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ppd_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  ppd_point_if.sink                                   pnt,
  ppd_result_if.source                                res,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [ppd_pkg::apb_addr_w(COORD_WIDTH)-1:0] paddr,
  input  logic [ppd_pkg::apb_data_w(COORD_WIDTH)-1:0] pwdata,
  output logic [ppd_pkg::apb_data_w(COORD_WIDTH)-1:0] prdata,
  output logic                                        pready
);
  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DTW = ((2*W > W+F) ? 2*W : W+F) + 2;
  localparam int MW  = DTW - 1;
  localparam int LO  = (MW + 1) / 2;
  localparam int HI  = MW - LO;
  localparam int NW  = 2*W;
  localparam int D2W = 2*MW;
  localparam int NMW = W + MW;
  localparam int QD  = 2*W;
  localparam int QF  = W + 1;
  localparam int FW  = W + 3;
  localparam int LAT = 3*W + 7;

  localparam logic signed [FW-1:0] SMAX = {{(FW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [FW-1:0] SMIN = ~SMAX;
  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic                  en;
  logic [LAT-1:0]        vld;

  logic [2:0][W-1:0]     plane_n;
  logic [W-1:0]          plane_d;
  logic [2:0][W-1:0]     nabs;
  logic [NW-1:0]         nn;
  ppd_pkg::plane_flags_t flags;

  logic [2:0][W-1:0]     pin;
  logic [2:0][2*W-1:0]   prod1;
  logic [W+F-1:0]        dterm1;
  logic [2:0][W-1:0]     pt1;
  logic                  degen1;
  logic [DTW-1:0]        dot2;
  logic [MW-1:0]         mag3;
  logic                  neg3;
  logic [2*HI-1:0]       hh4;
  logic [HI+LO-1:0]      hl4;
  logic [2*LO-1:0]       ll4;
  logic [2:0][W+HI-1:0]  nh4;
  logic [2:0][W+LO-1:0]  nl4;
  logic [D2W-1:0]        d2_5;
  logic [2:0][NMW-1:0]   fn5;

  logic [QD-1:0]         dq;
  logic                  dovf;
  logic                  dovf_f;
  logic [W-1:0]          droot;
  logic [2:0][QF-1:0]    fq;
  logic [2:0]            fovf;
  logic [2:0][QF-1:0]    fq_f;
  logic [2:0]            fovf_f;
  logic [2:0][W-1:0]     pt_f;
  logic                  degen_f;
  logic                  dneg_f;

  logic                  fneg [3];
  logic signed [FW-1:0]  offs [3];
  logic signed [FW-1:0]  fsum [3];
  logic [2:0][W-1:0]     fin_foot;
  logic [W-1:0]          fin_dist;
  logic                  fin_sat;

  ppd_regs #(
    .COORD_WIDTH (W),
    .FRAC_BITS   (F)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .plane_n (plane_n),
    .plane_d (plane_d),
    .nabs    (nabs),
    .nn      (nn),
    .flags   (flags)
  );

  assign pready = 1'b1;

  // the whole pipeline moves together unless the output register is held
  assign en        = res.ready || !vld[LAT-1];
  assign pnt.ready = en;
  assign res.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pnt.valid};
    end
  end

  assign pin = {pnt.point_z, pnt.point_y, pnt.point_x};

  // products of normal and point, offset scaled to the product format
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod1[i] <= (2*W)'($signed(plane_n[i]) * $signed(pin[i]));
      end
      dterm1 <= (W+F)'($signed(plane_d)) << F;
      pt1    <= pin;
      degen1 <= flags.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2 <= DTW'($signed(prod1[0])) + DTW'($signed(prod1[1]))
            + DTW'($signed(prod1[2])) + DTW'($signed(dterm1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag3 <= dot2[DTW-1] ? MW'(-dot2) : MW'(dot2);
      neg3 <= dot2[DTW-1];
    end
  end

  // split |dot| in two halves so each product stays near 32 by 32
  always_ff @(posedge clk) begin
    if (en) begin
      hh4 <= (2*HI)'(mag3[MW-1:LO]) * (2*HI)'(mag3[MW-1:LO]);
      hl4 <= (HI+LO)'(mag3[MW-1:LO]) * (HI+LO)'(mag3[LO-1:0]);
      ll4 <= (2*LO)'(mag3[LO-1:0]) * (2*LO)'(mag3[LO-1:0]);
      for (int i = 0; i < 3; i++) begin
        nh4[i] <= (W+HI)'(nabs[i]) * (W+HI)'(mag3[MW-1:LO]);
        nl4[i] <= (W+LO)'(nabs[i]) * (W+LO)'(mag3[LO-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_5 <= (D2W'(hh4) << (2*LO)) + (D2W'(hl4) << (LO+1)) + D2W'(ll4);
      for (int i = 0; i < 3; i++) begin
        fn5[i] <= (NMW'(nh4[i]) << LO) + NMW'(nl4[i]);
      end
    end
  end

  // distance: floor(sqrt(floor(dot^2 / |n|^2)))
  ppd_divider #(
    .NUM_W (D2W),
    .DEN_W (NW),
    .Q_W   (QD)
  ) u_ddiv (
    .clk (clk),
    .en  (en),
    .num (d2_5),
    .den (nn),
    .quo (dq),
    .ovf (dovf)
  );

  ppd_isqrt #(
    .ROOT_W (W)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (dq),
    .root (droot)
  );

  ppd_delay #(
    .WIDTH (1),
    .DEPTH (W)
  ) u_dovf_dly (
    .clk  (clk),
    .en   (en),
    .din  (dovf),
    .dout (dovf_f)
  );

  // foot offsets: |n_i| * |dot| / |n|^2, truncated
  for (genvar i = 0; i < 3; i++) begin : g_foot
    ppd_divider #(
      .NUM_W (NMW),
      .DEN_W (NW),
      .Q_W   (QF)
    ) u_fdiv (
      .clk (clk),
      .en  (en),
      .num (fn5[i]),
      .den (nn),
      .quo (fq[i]),
      .ovf (fovf[i])
    );

    ppd_delay #(
      .WIDTH (QF + 1),
      .DEPTH (2*W - 1)
    ) u_fq_dly (
      .clk  (clk),
      .en   (en),
      .din  ({fovf[i], fq[i]}),
      .dout ({fovf_f[i], fq_f[i]})
    );
  end

  ppd_delay #(
    .WIDTH (3*W + 1),
    .DEPTH (3*W + 5)
  ) u_pt_dly (
    .clk  (clk),
    .en   (en),
    .din  ({degen1, pt1}),
    .dout ({degen_f, pt_f})
  );

  ppd_delay #(
    .WIDTH (1),
    .DEPTH (3*W + 3)
  ) u_neg_dly (
    .clk  (clk),
    .en   (en),
    .din  (neg3),
    .dout (dneg_f)
  );

  always_comb begin
    fin_sat  = dovf_f;
    fin_dist = dovf_f ? '1 : droot;
    for (int i = 0; i < 3; i++) begin
      // offset takes the sign of -dot times n_i
      fneg[i] = flags.nneg[i] ^ ~dneg_f;
      offs[i] = fneg[i] ? -$signed(FW'(fq_f[i])) : $signed(FW'(fq_f[i]));
      fsum[i] = FW'($signed(pt_f[i])) + offs[i];
      if (fovf_f[i]) begin
        fin_foot[i] = fneg[i] ? CMIN : CMAX;
        fin_sat     = 1'b1;
      end else if (fsum[i] > SMAX) begin
        fin_foot[i] = CMAX;
        fin_sat     = 1'b1;
      end else if (fsum[i] < SMIN) begin
        fin_foot[i] = CMIN;
        fin_sat     = 1'b1;
      end else begin
        fin_foot[i] = fsum[i][W-1:0];
      end
    end
    // all-zero normal: report the point itself
    if (degen_f) begin
      fin_dist = '0;
      fin_foot = pt_f;
      fin_sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.distance         <= fin_dist;
      res.foot_x           <= fin_foot[0];
      res.foot_y           <= fin_foot[1];
      res.foot_z           <= fin_foot[2];
      res.degenerate_plane <= degen_f;
      res.saturated        <= fin_sat;
    end
  end

endmodule

@@ hdl/ppd_chk.sv @@
// port level checks for the point to plane block and the bind that attaches them
// depends on ppd_pkg and the top level point_plane_distance_projection
module ppd_chk #(
  parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] distance,
  input logic [COORD_WIDTH-1:0] foot_x,
  input logic [COORD_WIDTH-1:0] foot_y,
  input logic [COORD_WIDTH-1:0] foot_z,
  input logic                   degenerate_plane,
  input logic                   saturated
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(foot_x)
      && $stable(foot_y) && $stable(foot_z) && $stable(degenerate_plane)
      && $stable(saturated))
    else $error("stalled result changed");

  // the input side only stops when the output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (out_ready || !out_valid))
    else $error("input ready does not follow output stall");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate_plane |-> distance == '0 && !saturated)
    else $error("degenerate plane with nonzero distance or saturation");

endmodule

bind point_plane_distance_projection ppd_chk #(
  .COORD_WIDTH (COORD_WIDTH)
) u_ppd_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (pnt.valid),
  .in_ready         (pnt.ready),
  .out_valid        (res.valid),
  .out_ready        (res.ready),
  .distance         (res.distance),
  .foot_x           (res.foot_x),
  .foot_y           (res.foot_y),
  .foot_z           (res.foot_z),
  .degenerate_plane (res.degenerate_plane),
  .saturated        (res.saturated)
);

@@ bench/point_plane_distance_projection_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for the point to plane distance and foot point block
// depends on ppd_pkg, ppd_if and the rtl of point_plane_distance_projection
module point_plane_distance_projection_test;

  localparam int CW        = 32;
  localparam int FB        = 16;
  localparam int LATENCY   = 3 * CW + 7;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic        [CW-1:0] distance;
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
    logic signed [CW-1:0] foot_z;
    logic                 degenerate_plane;
    logic                 saturated;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ppd_pkg::apb_addr_w(CW)-1:0] paddr = '0;
  logic [ppd_pkg::apb_data_w(CW)-1:0] pwdata = '0;
  logic [ppd_pkg::apb_data_w(CW)-1:0] prdata;
  logic pready;

  ppd_point_if  #(.COORD_WIDTH(CW)) pnt_if ();
  ppd_result_if #(.COORD_WIDTH(CW)) res_if ();

  point_plane_distance_projection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .pnt(pnt_if), .res(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // plane as the bench believes it
  logic signed [CW-1:0] norm_a = '0, norm_b = '0, norm_c = 32'sd65536, offs_d = '0;

  point_t point_q[$];
  proj_t  proj_q[$];
  point_t drv_point = '0;
  int     errors = 0;
  bit     in_taken = 0;
  int     burst_left = 1, gap_left = 0;
  int     hold_req = 0, hold_seen = 0, hold_left = 0;
  int     rx_cycle = 0;
  int     idle_cycles = 0;

  function automatic logic [69:0] int_sqrt(logic [139:0] v);
    logic [69:0]  root;
    logic [69:0]  cand;
    logic [139:0] sq;
    root = '0;
    for (int i = 69; i >= 0; i--) begin
      cand = root | (70'd1 << i);
      sq = {70'd0, cand} * {70'd0, cand};
      if (sq <= v) root = cand;
    end
    return root;
  endfunction

  function automatic proj_t project_point(point_t p);
    logic signed [99:0] nv[3];
    logic signed [99:0] pv[3];
    logic signed [99:0] dot, nn, mag, off, sum;
    logic [139:0] quot;
    logic [69:0]  root;
    logic signed [CW-1:0] foot[3];
    proj_t r;
    nv[0] = norm_a; nv[1] = norm_b; nv[2] = norm_c;
    pv[0] = p.x; pv[1] = p.y; pv[2] = p.z;
    r = '0;
    if (norm_a == 0 && norm_b == 0 && norm_c == 0) begin
      r.foot_x = p.x; r.foot_y = p.y; r.foot_z = p.z;
      r.degenerate_plane = 1'b1;
      return r;
    end
    dot = nv[0] * pv[0] + nv[1] * pv[1] + nv[2] * pv[2];
    dot = dot + (100'(signed'(offs_d)) <<< FB);
    nn  = nv[0] * nv[0] + nv[1] * nv[1] + nv[2] * nv[2];
    mag = (dot < 0) ? -dot : dot;
    quot = ({40'd0, mag} * {40'd0, mag}) / {40'd0, nn};
    root = int_sqrt(quot);
    if (root > 70'hFFFF_FFFF) begin
      r.distance = '1;
      r.saturated = 1'b1;
    end else begin
      r.distance = root[CW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      // signed division truncates toward zero
      off = (nv[i] * (-dot)) / nn;
      sum = pv[i] + off;
      if (sum > 100'sd2147483647) begin
        foot[i] = 32'sh7FFF_FFFF;
        r.saturated = 1'b1;
      end else if (sum < -100'sd2147483648) begin
        foot[i] = 32'sh8000_0000;
        r.saturated = 1'b1;
      end else begin
        foot[i] = sum[CW-1:0];
      end
    end
    r.foot_x = foot[0]; r.foot_y = foot[1]; r.foot_z = foot[2];
    return r;
  endfunction

  // sender: bursts of requests with random gaps
  always @(negedge clk) begin
    logic nv;
    if (rst) begin
      pnt_if.valid <= 1'b0;
    end else if (!pnt_if.valid || in_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (point_q.size() > 0) begin
        drv_point = point_q.pop_front();
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      pnt_if.valid   <= nv;
      pnt_if.point_x <= drv_point.x;
      pnt_if.point_y <= drv_point.y;
      pnt_if.point_z <= drv_point.z;
    end
  end

  // receiver: own stall pattern plus the occasional long hold-off
  always @(negedge clk) begin
    logic r;
    rx_cycle++;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (rx_cycle[9:8] == 2'd0) begin
      r = 1'b1;
    end else begin
      r = ($urandom_range(0, 3) != 0);
    end
    res_if.ready <= rst ? 1'b0 : r;
  end

  // monitor: requests in, results out
  always @(posedge clk) begin
    proj_t want;
    in_taken = 0;
    if (!rst) begin
      if (pnt_if.valid && pnt_if.ready) begin
        in_taken = 1;
        proj_q.insert(proj_q.size(), project_point(drv_point));
      end
      if (res_if.valid && res_if.ready) begin
        if (proj_q.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          want = proj_q.pop_front();
          if (res_if.distance !== want.distance) begin
            $error("distance: expected %h, got %h", want.distance, res_if.distance);
            errors++;
          end
          if (res_if.foot_x !== want.foot_x) begin
            $error("foot_x: expected %h, got %h", want.foot_x, res_if.foot_x);
            errors++;
          end
          if (res_if.foot_y !== want.foot_y) begin
            $error("foot_y: expected %h, got %h", want.foot_y, res_if.foot_y);
            errors++;
          end
          if (res_if.foot_z !== want.foot_z) begin
            $error("foot_z: expected %h, got %h", want.foot_z, res_if.foot_z);
            errors++;
          end
          if (res_if.degenerate_plane !== want.degenerate_plane) begin
            $error("degenerate_plane: expected %b, got %b", want.degenerate_plane,
                   res_if.degenerate_plane);
            errors++;
          end
          if (res_if.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, res_if.saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pnt_if.valid && pnt_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("** point_plane_distance_projection: FAILED **");
      $finish;
    end
  end

  task automatic write_plane(ppd_pkg::reg_idx_t idx, logic [CW-1:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      ppd_pkg::REG_PLANE_A: norm_a = val;
      ppd_pkg::REG_PLANE_B: norm_b = val;
      ppd_pkg::REG_PLANE_C: norm_c = val;
      default:              offs_d = val;
    endcase
  endtask

  task automatic wait_drained();
    while (point_q.size() > 0 || pnt_if.valid || proj_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic queue_point(point_t p);
    point_q.insert(point_q.size(), p);
  endtask

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                     : -$urandom_range(0, 1 << 20);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  task automatic add_random(int count);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p.x = pick_coord(); p.y = pick_coord(); p.z = pick_coord();
      queue_point(p);
    end
  endtask

  task automatic add_corners();
    queue_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    queue_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    queue_point('{32'sd0, 32'sd0, 32'sd0});
    queue_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65536});
    queue_point('{-32'sd1, 32'sd1, -32'sd65536});
  endtask

  task automatic run_phase(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                           logic [CW-1:0] d, int count, bit long_hold);
    wait_drained();
    write_plane(ppd_pkg::REG_PLANE_A, a);
    write_plane(ppd_pkg::REG_PLANE_B, b);
    write_plane(ppd_pkg::REG_PLANE_C, c);
    write_plane(ppd_pkg::REG_PLANE_D, d);
    add_corners();
    add_random(count);
    if (long_hold) hold_req++;
  endtask

  initial begin
    pnt_if.valid = 1'b0;
    pnt_if.point_x = '0; pnt_if.point_y = '0; pnt_if.point_z = '0;
    res_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default plane straight after reset
    add_corners();
    queue_point('{32'sd65536, -32'sd65536, 32'sd123456});
    add_random(110);
    run_phase(32'd65536, 32'd0, 32'd0, -32'd327680, 120, 1'b1);
    run_phase(32'd0, 32'd0, 32'd0, 32'd12345, 100, 1'b0);
    run_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 120, 1'b0);
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 120, 1'b0);
    // tiny normal along x
    run_phase(32'd1, 32'd0, 32'd0, 32'd0, 100, 1'b0);
    run_phase($urandom, $urandom, $urandom, $urandom, 120, 1'b1);
    run_phase($urandom_range(0, 1 << 17), -$urandom_range(0, 1 << 17),
              $urandom_range(0, 1 << 17), $urandom, 120, 1'b0);
    run_phase($urandom, 32'd0, $urandom, $urandom_range(0, 1 << 20), 120, 1'b0);

    wait_drained();
    if (errors == 0) begin
      $display("** point_plane_distance_projection: PASSED **");
    end else begin
      $display("** point_plane_distance_projection: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ppd_pkg.sv
hdl/ppd_if.sv
hdl/ppd_regs.sv
hdl/ppd_delay.sv
hdl/ppd_divider.sv
hdl/ppd_isqrt.sv
hdl/point_plane_distance_projection.sv
hdl/ppd_chk.sv
bench/point_plane_distance_projection_test.sv
